FILE: rtl/sha256_pkg.sv
// sha256_pkg: shared types, constants and round functions for the sha-256 stream hasher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        final_word;
   } rsp_type;

   // command from front to back
   typedef enum logic [1:0] {
      CMD_BYTE  = 2'd0,
      CMD_LAST  = 2'd1,
      CMD_BLAST = 2'd2
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type code;
      logic [7:0]   data_byte;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_FILL  = 3'd0,
      ST_PAD   = 3'd1,
      ST_LEN   = 3'd2,
      ST_ROUND = 3'd3,
      ST_ADD   = 3'd4,
      ST_EMIT  = 3'd5
   } state_type;

   localparam int CmdQueueDepth = 4;
   localparam int CmdQueueAw    = 2;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_BYTE  = 8'h80;
   localparam logic [5:0] LEN_START = 6'd56;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] small_sig0(input logic [31:0] x);
      small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sig1(input logic [31:0] x);
      small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] big_sig0(input logic [31:0] x);
      big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sig1(input logic [31:0] x);
      big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage
`default_nettype wire

FILE: rtl/sha256_front.sv
// sha256_front: takes request transactions and classifies them into commands
// depends on sha256_pkg
`timescale 1ns / 1ps
`default_nettype none
module sha256_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire sha256_pkg::req_type  req_data,
   output logic                      cmd_valid,
   output sha256_pkg::cmd_type       cmd_data,
   input  wire logic                 cmd_pop
);

   sha256_pkg::cmd_type mem [sha256_pkg::CmdQueueDepth];
   logic [sha256_pkg::CmdQueueAw-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [sha256_pkg::CmdQueueAw:0]   count_ff, count_in;
   logic                              push_ok, is_cmd;
   sha256_pkg::cmd_type               new_cmd;

   always_comb begin
      new_cmd.data_byte = req_data.data_byte;
      if (req_data.last && req_data.has_byte) begin
         new_cmd.code = sha256_pkg::CMD_BLAST;
      end else if (req_data.last) begin
         new_cmd.code = sha256_pkg::CMD_LAST;
      end else begin
         new_cmd.code = sha256_pkg::CMD_BYTE;
      end
   end

   // an item with neither byte nor last is dropped here
   assign is_cmd   = req_data.has_byte | req_data.last;
   assign req_full = (count_ff == (sha256_pkg::CmdQueueAw+1)'(sha256_pkg::CmdQueueDepth));
   assign push_ok  = req_push & ~req_full & is_cmd;
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + sha256_pkg::CmdQueueAw'(push_ok);
      rd_ptr_in = rd_ptr_ff + sha256_pkg::CmdQueueAw'(cmd_pop & cmd_valid);
      count_in  = count_ff + (sha256_pkg::CmdQueueAw+1)'(push_ok)
                  - (sha256_pkg::CmdQueueAw+1)'(cmd_pop & cmd_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/sha256_core.sv
// sha256_core: block buffer, padding sequencer and one-round-per-cycle compression
// depends on sha256_pkg
`timescale 1ns / 1ps
`default_nettype none
module sha256_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 cmd_valid,
   input  wire sha256_pkg::cmd_type  cmd_data,
   output logic                      cmd_pop,
   output logic                      rsp_empty,
   output sha256_pkg::rsp_type       rsp_data,
   input  wire logic                 rsp_pop
);

   sha256_pkg::state_type state_ff, state_in;
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] h_ff [8];
   logic [31:0] h_in [8];
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  emit_ff, emit_in;
   logic        final_ff, final_in;   // compression in progress is the closing one
   logic        more_pad_ff, more_pad_in;   // a second padding block follows

   logic        do_byte, do_round, start_comp, closing;
   logic [7:0]  put_val;
   logic [31:0] t1, t2, w_next;
   logic [1:0]  lane;

   assign rsp_empty = (state_ff != sha256_pkg::ST_EMIT);
   assign rsp_data.digest_word = h_ff[emit_ff];
   assign rsp_data.word_index  = emit_ff;
   assign rsp_data.final_word  = (emit_ff == 3'd7);

   assign w_next = w_ff[0] + sha256_pkg::small_sig0(w_ff[1]) + w_ff[9]
                   + sha256_pkg::small_sig1(w_ff[14]);
   assign t1 = v_ff[7] + sha256_pkg::big_sig1(v_ff[4])
               + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
               + sha256_pkg::ROUND_K[round_ff] + w_ff[0];
   assign t2 = sha256_pkg::big_sig0(v_ff[0])
               + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   assign lane = fill_ff[1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha256_pkg::ST_FILL: begin
            if (cmd_valid) begin
               if (cmd_data.code == sha256_pkg::CMD_BYTE) begin
                  if (fill_ff == 6'd63) state_in = sha256_pkg::ST_ROUND;
               end else if (cmd_data.code == sha256_pkg::CMD_BLAST) begin
                  if (fill_ff == 6'd63) state_in = sha256_pkg::ST_ROUND;
                  else state_in = sha256_pkg::ST_PAD;
               end else begin
                  state_in = sha256_pkg::ST_PAD;
               end
            end
         end
         sha256_pkg::ST_PAD: begin
            if (fill_ff == 6'd63) state_in = sha256_pkg::ST_ROUND;
            else if (fill_ff == sha256_pkg::LEN_START - 6'd1)
               state_in = sha256_pkg::ST_LEN;
         end
         sha256_pkg::ST_LEN:   state_in = sha256_pkg::ST_ROUND;
         sha256_pkg::ST_ROUND: if (round_ff == 6'd63) state_in = sha256_pkg::ST_ADD;
         sha256_pkg::ST_ADD: begin
            if (final_ff) state_in = sha256_pkg::ST_EMIT;
            else if (closing || more_pad_ff) state_in = sha256_pkg::ST_PAD;
            else state_in = sha256_pkg::ST_FILL;
         end
         sha256_pkg::ST_EMIT: if (rsp_pop && emit_ff == 3'd7) state_in = sha256_pkg::ST_FILL;
         default: state_in = sha256_pkg::ST_FILL;
      endcase
   end

   // closing_ff tracks that padding is pending across a mid-message compression
   logic closing_ff, closing_in;
   assign closing = closing_ff;

   // outputs and datapath control
   always_comb begin
      cmd_pop     = 1'b0;
      do_byte     = 1'b0;
      put_val     = cmd_data.data_byte;
      do_round    = 1'b0;
      start_comp  = 1'b0;
      closing_in  = closing_ff;
      final_in    = final_ff;
      more_pad_in = more_pad_ff;
      unique case (state_ff)
         sha256_pkg::ST_FILL: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd_data.code != sha256_pkg::CMD_LAST) do_byte = 1'b1;
               if (cmd_data.code != sha256_pkg::CMD_BYTE) closing_in = 1'b1;
               if (cmd_data.code != sha256_pkg::CMD_LAST && fill_ff == 6'd63)
                  start_comp = 1'b1;
            end
         end
         sha256_pkg::ST_PAD: begin
            do_byte = 1'b1;
            // first pad position after the message takes the marker byte
            put_val = closing_ff ? sha256_pkg::PAD_BYTE : 8'd0;
            closing_in = 1'b0;
            // no room for the length, it goes into one more block of zeros
            if (fill_ff == 6'd63) begin
               start_comp  = 1'b1;
               more_pad_in = 1'b1;
            end
         end
         sha256_pkg::ST_LEN: begin
            start_comp = 1'b1;
            final_in   = 1'b1;
         end
         sha256_pkg::ST_ROUND: do_round = 1'b1;
         sha256_pkg::ST_ADD: more_pad_in = 1'b0;
         sha256_pkg::ST_EMIT: if (rsp_pop && emit_ff == 3'd7) final_in = 1'b0;
         default: ;
      endcase
   end

   always_comb begin
      w_in     = w_ff;
      v_in     = v_ff;
      h_in     = h_ff;
      fill_in  = fill_ff;
      bits_in  = bits_ff;
      round_in = round_ff;
      emit_in  = emit_ff;
      if (do_byte) begin
         unique case (lane)
            2'd0: w_in[fill_ff[5:2]][31:24] = put_val;
            2'd1: w_in[fill_ff[5:2]][23:16] = put_val;
            2'd2: w_in[fill_ff[5:2]][15:8]  = put_val;
            2'd3: w_in[fill_ff[5:2]][7:0]   = put_val;
            default: ;
         endcase
         fill_in = fill_ff + 6'd1;
         if (state_ff == sha256_pkg::ST_FILL) bits_in = bits_ff + 64'd8;
      end
      if (state_ff == sha256_pkg::ST_LEN) begin
         w_in[14] = bits_ff[63:32];
         w_in[15] = bits_ff[31:0];
      end
      if (start_comp) begin
         round_in = 6'd0;
         for (int i = 0; i < 8; i++) v_in[i] = h_ff[i];
      end
      if (do_round) begin
         // schedule slides one word per round
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
         w_in[15] = w_next;
         for (int i = 1; i < 8; i++) v_in[i] = v_ff[i-1];
         v_in[4]  = v_ff[3] + t1;
         v_in[0]  = t1 + t2;
         round_in = round_ff + 6'd1;
      end
      if (state_ff == sha256_pkg::ST_ADD) begin
         for (int i = 0; i < 8; i++) h_in[i] = h_ff[i] + v_ff[i];
      end
      if (state_ff == sha256_pkg::ST_EMIT && rsp_pop) begin
         emit_in = emit_ff + 3'd1;
         if (emit_ff == 3'd7) begin
            for (int i = 0; i < 8; i++) h_in[i] = sha256_pkg::INIT_HASH[i];
            fill_in = 6'd0;
            bits_in = 64'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sha256_pkg::ST_FILL;
         fill_ff     <= '0;
         bits_ff     <= '0;
         emit_ff     <= '0;
         closing_ff  <= 1'b0;
         final_ff    <= 1'b0;
         more_pad_ff <= 1'b0;
         for (int i = 0; i < 8; i++) h_ff[i] <= sha256_pkg::INIT_HASH[i];
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         bits_ff     <= bits_in;
         emit_ff     <= emit_in;
         closing_ff  <= closing_in;
         final_ff    <= final_in;
         more_pad_ff <= more_pad_in;
         h_ff        <= h_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff     <= w_in;
      v_ff     <= v_in;
      round_ff <= round_in;
   end

endmodule
`default_nettype wire

FILE: rtl/sha256_stream_hasher.sv
// sha256_stream_hasher: top level, command queue front end and compression back end
// depends on sha256_pkg, sha256_front, sha256_core
// a byte is taken per cycle while the back end fills and the queue holds one; the byte that
// completes a block also loads the round registers, then 64 rounds and the hash add hold
// the back end, during which the queue absorbs up to four transactions. a last transaction
// adds padding plus one or two compressions, then eight digest words leave one per pop.
// synchronous reset loads the initial hash and empties the queue.
`timescale 1ns / 1ps
`default_nettype none
module sha256_stream_hasher (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire sha256_pkg::req_type  req_data,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output sha256_pkg::rsp_type       rsp_data
);

   logic                cmd_valid, cmd_pop;
   sha256_pkg::cmd_type cmd_data;

   sha256_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   sha256_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop)
   );

   a_final_ends: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_data.final_word) |=> rsp_empty)
      else $error("digest did not end after final word");

   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_data.final_word) |=>
      (!rsp_empty && rsp_data.word_index == $past(rsp_data.word_index) + 3'd1))
      else $error("digest word index skipped");

   a_no_pop_while_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command taken from empty queue");

endmodule
`default_nettype wire
